// ----- rtl/bff_pkg.sv -----
// Shared types and defaults for the allocation-flag bit map.
// No dependencies; imported by bitmap_find_first_set and its bench.
package bff_pkg;

   localparam int DEF_WORD_BITS = 64;
   localparam int DEF_MAX_BITS  = 4096;

   localparam int CMD_W   = 2;
   localparam int IDX_W   = 12;
   localparam int CFG_W   = 13;
   localparam int TDATA_W = 16;

   localparam logic [CFG_W-1:0] BITS_RESET = 13'd4096;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_FIND  = 2'd2,
      CMD_FILL  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_ADDR,
      ST_ACCESS,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_FILL
   } state_type;

endpackage

// ----- rtl/bff_lsb.sv -----
// Lowest-set-bit encoder for one flag word.
// Depends on nothing but its WORD_BITS parameter.
module bff_lsb #(
   parameter int WORD_BITS = 64
) (
   input  logic [WORD_BITS-1:0]         word,
   output logic                         nonzero,
   output logic [$clog2(WORD_BITS)-1:0] pos
);
   localparam int PW = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0] lowest;

   assign lowest  = word & (~word + WORD_BITS'(1));
   assign nonzero = |word;

   always_comb begin
      pos = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (lowest[j]) begin
            pos = pos | PW'(j);
         end
      end
   end

endmodule

// ----- rtl/bitmap_find_first_set.sv -----
// Allocation-flag bit map with write, read, find-first-set and fill commands.
// Depends on bff_pkg and bff_lsb.
//
// One item at a time over a single-port word memory. After reset the block
// sweeps every word to all ones, one word a cycle, before it takes the first
// item. A write or read passes the index split (reciprocal multiply), the
// memory read and the step that modifies or picks the bit; no new item is
// taken until the block is back in idle. Find reads each word in use in turn
// and encodes its lowest set bit, and reports not found after the last word
// when none turns up; fill writes each word in use. Each command waits in its
// last step until the output register is free. The next item is accepted
// while the result still waits in the output register.
module bitmap_find_first_set #(
   parameter int WORD_BITS = bff_pkg::DEF_WORD_BITS,
   parameter int MAX_BITS  = bff_pkg::DEF_MAX_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   // cmd [1:0], bit_index [13:2], bit_value [14], zero [15]
   input  logic [bff_pkg::TDATA_W-1:0]  req_tdata,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // bit_out [0], found [1], found_index [13:2], range_error [14], zero [15]
   output logic [bff_pkg::TDATA_W-1:0]  rsp_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic                         csr_we,
   input  logic [bff_pkg::CFG_W-1:0]    csr_wdata
);
   import bff_pkg::*;

   localparam int NWORDS    = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int PW        = $clog2(WORD_BITS);
   localparam int SPAN_W    = $clog2(NWORDS * WORD_BITS + 1);
   localparam int CW        = (SPAN_W > CFG_W) ? SPAN_W : CFG_W;
   localparam int DIV_SHIFT = IDX_W + 7;
   localparam int RECIP     = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;

   logic [WORD_BITS-1:0] mem [NWORDS];

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 val_ff, val_in;
   logic [IDX_W-1:0]     q_ff, q_in;
   logic [PW-1:0]        b_ff, b_in;
   logic                 range_ff, range_in;
   logic [AW-1:0]        i_ff, i_in;
   logic [CW-1:0]        base_ff, base_in;
   logic [WORD_BITS-1:0] rd_ff;
   logic [CFG_W-1:0]     bits_ff;
   logic                 rsp_valid_ff;
   logic [TDATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                 mem_we, mem_re;
   logic [AW-1:0]        mem_addr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic                 rsp_load, out_free;
   logic [CW-1:0]        cap, wbase;
   logic [31:0]          prod;
   logic                 lsb_nz;
   logic [PW-1:0]        lsb_pos;
   logic [CW-1:0]        hit_index;
   logic [WORD_BITS-1:0] bit_mask;

   bff_lsb #(.WORD_BITS(WORD_BITS)) u_lsb (
      .word    (rd_ff),
      .nonzero (lsb_nz),
      .pos     (lsb_pos)
   );

   assign cap       = (CW'(bits_ff) < CW'(MAX_BITS)) ? CW'(bits_ff) : CW'(MAX_BITS);
   assign prod      = 32'(idx_ff) * 32'(RECIP);
   assign wbase     = CW'(q_ff) * CW'(WORD_BITS);
   assign hit_index = base_ff + CW'(lsb_pos);
   assign bit_mask  = WORD_BITS'(1) << b_ff;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      val_in      = val_ff;
      q_in        = q_ff;
      b_in        = b_ff;
      range_in    = range_ff;
      i_in        = i_ff;
      base_in     = base_ff;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_addr    = i_ff;
      mem_wdata   = '1;
      rsp_load    = 1'b0;
      rsp_data_in = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            i_in   = i_ff + AW'(1);
            if (i_ff == AW'(NWORDS - 1)) begin
               i_in     = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in  = cmd_type'(req_tdata[1:0]);
               idx_in  = req_tdata[13:2];
               val_in  = req_tdata[14];
               i_in    = '0;
               base_in = '0;
               unique case (cmd_type'(req_tdata[1:0]))
                  CMD_WRITE, CMD_READ: state_in = ST_DIV;
                  CMD_FIND:            state_in = ST_FIND_RD;
                  CMD_FILL:            state_in = ST_FILL;
                  default:             state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIV: begin
            q_in     = prod[DIV_SHIFT +: IDX_W];
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            b_in     = PW'(CW'(idx_ff) - wbase);
            range_in = !(wbase < cap);
            mem_re   = 1'b1;
            mem_addr = AW'(q_ff);
            state_in = ST_ACCESS;
         end
         ST_ACCESS: begin
            mem_addr = AW'(q_ff);
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               if (range_ff) begin
                  rsp_data_in[14] = 1'b1;
               end else if (cmd_ff == CMD_WRITE) begin
                  mem_we    = 1'b1;
                  mem_wdata = val_ff ? (rd_ff | bit_mask) : (rd_ff & ~bit_mask);
               end else begin
                  rsp_data_in[0] = rd_ff[b_ff];
               end
            end
         end
         ST_FIND_RD: begin
            if (base_ff >= cap) begin
               if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               mem_re   = 1'b1;
               state_in = ST_FIND_CHK;
            end
         end
         ST_FIND_CHK: begin
            if (lsb_nz) begin
               if (out_free) begin
                  rsp_load          = 1'b1;
                  rsp_data_in[1]    = 1'b1;
                  rsp_data_in[13:2] = hit_index[IDX_W-1:0];
                  state_in          = ST_IDLE;
               end
            end else begin
               i_in     = i_ff + AW'(1);
               base_in  = base_ff + CW'(WORD_BITS);
               state_in = ST_FIND_RD;
            end
         end
         ST_FILL: begin
            if (base_ff >= cap) begin
               if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               mem_we    = 1'b1;
               mem_wdata = val_ff ? '1 : '0;
               i_in      = i_ff + AW'(1);
               base_in   = base_ff + CW'(WORD_BITS);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         i_ff         <= '0;
         bits_ff      <= BITS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         if (csr_we) begin
            bits_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      idx_ff   <= idx_in;
      val_ff   <= val_in;
      q_ff     <= q_in;
      b_ff     <= b_in;
      range_ff <= range_in;
      base_ff  <= base_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_addr];
      end
   end

endmodule

// ----- verif/bitmap_find_first_set_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for bitmap_find_first_set: directed and random commands over
// a stream handshake with random stalls, scored against a flag-map predictor.
// Depends on bff_pkg and the bitmap_find_first_set RTL.

typedef struct {
   logic        bit_out;
   logic        found;
   logic [11:0] found_index;
   logic        range_error;
} flag_result_type;

class flag_map_scoreboard;
   logic [63:0]     flag_words [64];
   logic [12:0]     bits_in_use;
   flag_result_type pending_results [$];
   int              mismatches;

   function new();
      foreach (flag_words[i]) flag_words[i] = '1;
      bits_in_use = bff_pkg::BITS_RESET;
      mismatches  = 0;
   endfunction

   function void set_bit_count(logic [12:0] count);
      bits_in_use = count;
   endfunction

   function int words_in_use();
      int b;
      b = bits_in_use;
      if (b > bff_pkg::DEF_MAX_BITS) b = bff_pkg::DEF_MAX_BITS;
      return (b + bff_pkg::DEF_WORD_BITS - 1) / bff_pkg::DEF_WORD_BITS;
   endfunction

   function void apply_command(bff_pkg::cmd_type cmd, logic [11:0] idx, logic val);
      flag_result_type r;
      int              nw;
      int              w;
      int              b;
      int              i;
      r.bit_out     = 1'b0;
      r.found       = 1'b0;
      r.found_index = '0;
      r.range_error = 1'b0;
      nw = words_in_use();
      w  = idx / bff_pkg::DEF_WORD_BITS;
      b  = idx % bff_pkg::DEF_WORD_BITS;
      case (cmd)
         bff_pkg::CMD_WRITE: begin
            if (w >= nw) r.range_error = 1'b1;
            else flag_words[w][b] = val;
         end
         bff_pkg::CMD_READ: begin
            if (w >= nw) r.range_error = 1'b1;
            else r.bit_out = flag_words[w][b];
         end
         bff_pkg::CMD_FIND: begin
            for (i = 0; i < nw && !r.found; i++) begin
               if (flag_words[i] != '0) begin
                  b = 0;
                  while (!flag_words[i][b]) b++;
                  r.found       = 1'b1;
                  r.found_index = 12'(i * bff_pkg::DEF_WORD_BITS + b);
               end
            end
         end
         default: begin
            for (i = 0; i < nw; i++) flag_words[i] = {64{val}};
         end
      endcase
      pending_results.push_back(r);
   endfunction

   function void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   function void check_result(logic [15:0] tdata);
      flag_result_type exp_r;
      if (pending_results.size() == 0) begin
         $display("%0t: result %h expected none actual one", $time, tdata);
         mismatches++;
         return;
      end
      exp_r = pending_results.pop_front();
      compare_field("bit_out", exp_r.bit_out, tdata[0]);
      compare_field("found", exp_r.found, tdata[1]);
      compare_field("found_index", exp_r.found_index, tdata[13:2]);
      compare_field("range_error", exp_r.range_error, tdata[14]);
   endfunction
endclass

module bitmap_find_first_set_test;
   import bff_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 500;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 120;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic [TDATA_W-1:0]  req_tdata  = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [TDATA_W-1:0]  rsp_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic                csr_we     = 1'b0;
   logic [CFG_W-1:0]    csr_wdata  = '0;

   flag_map_scoreboard  scoreboard = new();
   bit                  hold_due   = 1'b0;
   bit                  no_gaps    = 1'b0;
   int                  idle_cycles = 0;

   bitmap_find_first_set i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) scoreboard.check_result(rsp_tdata);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int on_cycles;
      int off_cycles;
      int roll;
      forever begin
         if (hold_due) begin
            hold_due = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if ($urandom_range(0, 9) == 0) on_cycles = $urandom_range(50, 200);
            else on_cycles = $urandom_range(1, 12);
            roll = $urandom_range(0, 19);
            if (roll < 8) off_cycles = 0;
            else if (roll < 18) off_cycles = $urandom_range(1, 4);
            else off_cycles = $urandom_range(20, 70);
            rsp_tready <= 1'b1;
            repeat (on_cycles) @(posedge clock);
            if (off_cycles > 0) begin
               rsp_tready <= 1'b0;
               repeat (off_cycles) @(posedge clock);
            end
         end
      end
   end

   task automatic send_command(cmd_type cmd, logic [11:0] idx, logic val);
      int gap;
      int roll;
      roll = $urandom_range(0, 49);
      if (no_gaps || roll < 28) gap = 0;
      else if (roll < 44) gap = $urandom_range(1, 3);
      else if (roll < 49) gap = $urandom_range(4, 15);
      else gap = $urandom_range(30, 80);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, val, idx, cmd};
      do @(posedge clock); while (!req_tready);
      scoreboard.apply_command(cmd, idx, val);
   endtask

   task automatic set_bit_count(logic [12:0] count);
      req_tvalid <= 1'b0;
      while (scoreboard.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= count;
      @(posedge clock);
      csr_we <= 1'b0;
      scoreboard.set_bit_count(count);
   endtask

   initial begin
      int          phase;
      int          n;
      int          nw;
      int          roll;
      int          items_sent;
      logic [12:0] count;
      cmd_type     cmd;
      logic [11:0] idx;
      logic        val;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_command(CMD_READ, 12'd0, 1'b0);
      send_command(CMD_READ, 12'd4095, 1'b1);
      send_command(CMD_FIND, 12'd0, 1'b0);
      send_command(CMD_FILL, 12'd4095, 1'b0);
      send_command(CMD_FIND, 12'd0, 1'b0);
      send_command(CMD_WRITE, 12'd4095, 1'b1);
      send_command(CMD_FIND, 12'd0, 1'b0);
      send_command(CMD_WRITE, 12'd69, 1'b1);
      send_command(CMD_FIND, 12'd0, 1'b0);
      send_command(CMD_READ, 12'd4094, 1'b0);
      send_command(CMD_WRITE, 12'd4095, 1'b0);
      send_command(CMD_READ, 12'd4095, 1'b0);
      send_command(CMD_FILL, 12'd0, 1'b1);
      send_command(CMD_FIND, 12'd0, 1'b0);

      set_bit_count(13'd0);
      send_command(CMD_WRITE, 12'd0, 1'b0);
      send_command(CMD_READ, 12'd0, 1'b0);
      send_command(CMD_FIND, 12'd0, 1'b0);
      send_command(CMD_FILL, 12'd0, 1'b0);

      set_bit_count(13'd65);
      send_command(CMD_READ, 12'd127, 1'b0);
      send_command(CMD_READ, 12'd128, 1'b0);
      send_command(CMD_FILL, 12'd0, 1'b0);
      send_command(CMD_FIND, 12'd0, 1'b0);

      set_bit_count(13'd8191);
      send_command(CMD_FIND, 12'd0, 1'b0);

      set_bit_count(13'd1);
      send_command(CMD_READ, 12'd63, 1'b0);
      send_command(CMD_WRITE, 12'd64, 1'b1);

      items_sent = 0;
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: count = 13'd4096;
            1: count = 13'd1;
            2: count = 13'd8191;
            3: count = 13'd0;
            4: count = 13'd64;
            default: begin
               roll = $urandom_range(0, 3);
               if (roll == 0) count = 13'($urandom_range(1, 4096));
               else if (roll == 1) count = 13'($urandom_range(1, 512));
               else if (roll == 2) count = 13'($urandom_range(4097, 8191));
               else count = 13'($urandom_range(0, 200));
            end
         endcase
         set_bit_count(count);
         no_gaps = (phase % 3 == 2);
         nw = scoreboard.words_in_use();
         for (n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 35) cmd = CMD_WRITE;
            else if (roll < 60) cmd = CMD_READ;
            else if (roll < 88) cmd = CMD_FIND;
            else cmd = CMD_FILL;
            if (nw > 0 && $urandom_range(0, 4) != 0) idx = 12'($urandom_range(0, nw * 64 - 1));
            else idx = 12'($urandom());
            if (cmd == CMD_FILL) val = ($urandom_range(0, 3) == 0);
            else val = 1'($urandom_range(0, 1));
            if (items_sent == 350 || items_sent == 900) hold_due = 1'b1;
            send_command(cmd, idx, val);
            items_sent++;
         end
      end

      req_tvalid <= 1'b0;
      while (scoreboard.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (scoreboard.mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
